// ----- design/wsd_pkg.sv -----
`default_nettype none
package wsd_pkg;

  localparam int unsigned LEN_W = 64;
  localparam int unsigned KEY_W = 32;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic ERR_NIBBLE = 1'b0;
  localparam logic ERR_OPCODE = 1'b1;

  localparam logic [3:0] NIB_MORE  = 4'h0;
  localparam logic [3:0] NIB_FINAL = 4'h8;

  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;
  localparam logic [3:0] OP_PONG   = 4'd10;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [2:0] CNT_EXT16 = 3'd1;
  localparam logic [2:0] CNT_EXT64 = 3'd7;
  localparam logic [2:0] CNT_KEY   = 3'd3;

  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_EXTLEN  = 6'b000100,
    PH_MASK    = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_ERROR   = 6'b100000
  } wsd_phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } wsd_in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       payload_byte;
    logic [3:0]       frame_opcode;
    logic             final_fragment;
    logic             was_masked;
    logic [LEN_W-1:0] frame_length;
    logic             last_of_frame;
    logic             error_code;
  } wsd_out_t;

endpackage
`default_nettype wire

// ----- design/wsd_stream_if.sv -----
`default_nettype none
interface wsd_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/websocket_frame_deframer.sv -----
// WebSocket (RFC 6455) frame deframer. Takes one received byte per request on rx and
// gives at most one request on result per byte: a header record once the header
// (including extended length and masking key) is complete, then each payload byte
// unmasked, the last one flagged. A bad FIN/RSV nibble or opcode gives one error
// record, after which bytes are swallowed until reset. Each byte is handled
// combinationally between the parser state and the result register, so one byte per
// clock is sustained; rx stalls only while the result register holds a record that
// result has not taken. Fragment mask reuse follows the first non-final fragment.
`default_nettype none
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  wsd_stream_if.sink    rx,
  wsd_stream_if.source  result
);

  wsd_phase_t       phase, phase_next;
  logic [2:0]       field_cnt, field_cnt_next;
  logic [3:0]       cur_opcode, cur_opcode_next;
  logic             cur_final, cur_final_next;
  logic             cur_masked, cur_masked_next;
  logic [LEN_W-1:0] length_value, length_value_next;
  logic [LEN_W-1:0] remaining, remaining_next;
  logic [KEY_W-1:0] mask_key, mask_key_next;
  logic [1:0]       mask_pos, mask_pos_next;
  logic             frag_open, frag_open_next;
  logic             frag_masked, frag_masked_next;
  logic [KEY_W-1:0] frag_key, frag_key_next;

  logic             res_valid;
  wsd_out_t         res, res_next;
  logic             emit;
  logic             accept;

  logic [7:0]       b;
  logic [3:0]       nib;
  logic [3:0]       op;
  logic             op_ok;
  logic             do_after;
  logic             do_finish;
  logic [7:0]       kb;

  assign b        = rx.payload.rx_byte;
  assign nib      = b[7:4];
  assign op       = b[3:0];
  assign rx.ready = !res_valid || result.ready;
  assign accept   = rx.valid && rx.ready;

  assign result.valid   = res_valid;
  assign result.payload = res;

  always_comb begin
    case (op) inside
      OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: op_ok = 1'b1;
      default: op_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    field_cnt_next    = field_cnt;
    cur_opcode_next   = cur_opcode;
    cur_final_next    = cur_final;
    cur_masked_next   = cur_masked;
    length_value_next = length_value;
    remaining_next    = remaining;
    mask_key_next     = mask_key;
    mask_pos_next     = mask_pos;
    frag_open_next    = frag_open;
    frag_masked_next  = frag_masked;
    frag_key_next     = frag_key;
    res_next          = '0;
    emit              = 1'b0;
    do_after          = 1'b0;
    do_finish         = 1'b0;
    kb                = 8'h00;

    unique case (phase)
      PH_HDR0: begin
        if (nib != NIB_MORE && nib != NIB_FINAL) begin
          phase_next          = PH_ERROR;
          emit                = 1'b1;
          res_next.kind       = KIND_ERROR;
          res_next.error_code = ERR_NIBBLE;
        end else if (!op_ok) begin
          phase_next          = PH_ERROR;
          emit                = 1'b1;
          res_next.kind       = KIND_ERROR;
          res_next.error_code = ERR_OPCODE;
        end else begin
          cur_final_next    = (nib == NIB_FINAL);
          cur_opcode_next   = op;
          cur_masked_next   = 1'b0;
          length_value_next = '0;
          mask_key_next     = '0;
          phase_next        = PH_HDR1;
        end
      end
      PH_HDR1: begin
        cur_masked_next = b[7];
        if (b[6:0] == LEN7_EXT16) begin
          phase_next     = PH_EXTLEN;
          field_cnt_next = CNT_EXT16;
        end else if (b[6:0] == LEN7_EXT64) begin
          phase_next     = PH_EXTLEN;
          field_cnt_next = CNT_EXT64;
        end else begin
          length_value_next = {{(LEN_W-7){1'b0}}, b[6:0]};
          do_after          = 1'b1;
        end
      end
      PH_EXTLEN: begin
        length_value_next = {length_value[LEN_W-9:0], b};
        if (field_cnt == 3'd0) begin
          do_after = 1'b1;
        end else begin
          field_cnt_next = field_cnt - 3'd1;
        end
      end
      PH_MASK: begin
        mask_key_next = {mask_key[KEY_W-9:0], b};
        if (field_cnt == 3'd0) begin
          do_finish = 1'b1;
        end else begin
          field_cnt_next = field_cnt - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        case (mask_pos)
          2'd0:    kb = mask_key[31:24];
          2'd1:    kb = mask_key[23:16];
          2'd2:    kb = mask_key[15:8];
          default: kb = mask_key[7:0];
        endcase
        if (!cur_masked) begin
          kb = 8'h00;
        end
        mask_pos_next           = mask_pos + 2'd1;
        remaining_next          = remaining - {{(LEN_W-1){1'b0}}, 1'b1};
        emit                    = 1'b1;
        res_next.kind           = KIND_PAYLOAD;
        res_next.payload_byte   = b ^ kb;
        res_next.frame_opcode   = cur_opcode;
        res_next.final_fragment = cur_final;
        res_next.was_masked     = cur_masked;
        res_next.frame_length   = length_value;
        if (remaining_next == '0) begin
          res_next.last_of_frame = 1'b1;
          phase_next             = PH_HDR0;
        end
      end
      PH_ERROR: begin
        phase_next = PH_ERROR;
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase

    if (do_after) begin
      if (cur_masked_next) begin
        phase_next     = PH_MASK;
        field_cnt_next = CNT_KEY;
      end else begin
        do_finish = 1'b1;
      end
    end

    if (do_finish) begin
      if (!cur_final_next) begin
        if (!frag_open) begin
          frag_open_next   = 1'b1;
          frag_masked_next = cur_masked_next;
          frag_key_next    = mask_key_next;
        end else begin
          cur_masked_next = frag_masked;
          mask_key_next   = frag_key;
        end
      end else begin
        frag_open_next   = 1'b0;
        frag_masked_next = 1'b0;
        frag_key_next    = '0;
      end
      if (!cur_masked_next) begin
        mask_key_next = '0;
      end
      remaining_next          = length_value_next;
      mask_pos_next           = 2'd0;
      emit                    = 1'b1;
      res_next.kind           = KIND_HEADER;
      res_next.frame_opcode   = cur_opcode_next;
      res_next.final_fragment = cur_final_next;
      res_next.was_masked     = cur_masked_next;
      res_next.frame_length   = length_value_next;
      if (length_value_next == '0) begin
        res_next.last_of_frame = 1'b1;
        phase_next             = PH_HDR0;
      end else begin
        phase_next = PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      field_cnt    <= 3'd0;
      cur_opcode   <= 4'd0;
      cur_final    <= 1'b0;
      cur_masked   <= 1'b0;
      length_value <= '0;
      remaining    <= '0;
      mask_key     <= '0;
      mask_pos     <= 2'd0;
      frag_open    <= 1'b0;
      frag_masked  <= 1'b0;
      frag_key     <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        field_cnt    <= field_cnt_next;
        cur_opcode   <= cur_opcode_next;
        cur_final    <= cur_final_next;
        cur_masked   <= cur_masked_next;
        length_value <= length_value_next;
        remaining    <= remaining_next;
        mask_key     <= mask_key_next;
        mask_pos     <= mask_pos_next;
        frag_open    <= frag_open_next;
        frag_masked  <= frag_masked_next;
        frag_key     <= frag_key_next;
      end
      if (accept && emit) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res <= res_next;
    end
  end

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_ERROR) |-> (phase == PH_ERROR))
    else $error("error record held outside error phase");

  a_mid_payload: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_PAYLOAD && !res.last_of_frame) |-> (phase == PH_PAYLOAD))
    else $error("payload record not last but parser left payload");

  a_empty_header: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_HEADER && res.last_of_frame) |-> (res.frame_length == '0))
    else $error("empty-frame header with nonzero length");

  a_frag_mask: assert property (@(posedge clk) disable iff (rst)
    !frag_open |-> (!frag_masked && frag_key == '0))
    else $error("saved fragment mask without open fragment");

endmodule
`default_nettype wire
